### src/alr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alr_pkg
// Shared types and constants of the audio loop recorder.
// ----------------------------------------------------------------------------
package alr_pkg;

    // Widths fixed by the beat and register formats.
    localparam int SAMPLE_W   = 16;
    localparam int BYTE_W     = 8;
    localparam int OP_W       = 2;
    localparam int OCT_W      = 2;
    localparam int CAP_W      = 18;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 18;

    // Command codes carried by an input beat.
    typedef enum logic [OP_W-1:0] {
        OP_TICK   = 2'd0,
        OP_RECORD = 2'd1,
        OP_PLAY   = 2'd2,
        OP_STOP   = 2'd3
    } op_t;

    // Register indexes on the configuration port.
    localparam logic [CFG_IDX_W-1:0] CFG_OCTAVE   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY = 1'd1;

    // Playback rate codes.
    localparam logic [OCT_W-1:0] OCT_HALF   = 2'd0;
    localparam logic [OCT_W-1:0] OCT_NORMAL = 2'd1;
    localparam logic [OCT_W-1:0] OCT_DOUBLE = 2'd2;

    // Register reset values.
    localparam logic [OCT_W-1:0] OCT_RESET = OCT_NORMAL;
    localparam logic [CAP_W-1:0] CAP_RESET = 18'd131072;

    // Sign flip that maps an offset byte to and from two's complement.
    localparam logic [BYTE_W-1:0] BYTE_OFFSET = 8'h80;

    // Memory access requested for one accepted beat.
    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } mem_ctl_t;

    // What the output stage needs to know about one accepted beat.
    typedef struct packed {
        logic use_byte;  // output comes from the store read
        logic play;      // beat was a playback tick
        logic full;      // full flag after this beat
    } beat_info_t;

endpackage

### src/alr_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alr_if
// Valid/ready channels for command beats and result beats.
// ----------------------------------------------------------------------------
interface alr_in_if;
    logic                                valid;
    logic                                ready;
    logic [alr_pkg::OP_W-1:0]            op;
    logic signed [alr_pkg::SAMPLE_W-1:0] in_sample;

    modport source (output valid, output op, output in_sample, input ready);
    modport sink   (input valid, input op, input in_sample, output ready);
endinterface

interface alr_out_if;
    logic                                valid;
    logic                                ready;
    logic signed [alr_pkg::SAMPLE_W-1:0] out_sample;
    logic                                out_valid;
    logic                                store_full;

    modport source (output valid, output out_sample, output out_valid,
                    output store_full, input ready);
    modport sink   (input valid, input out_sample, input out_valid,
                    input store_full, output ready);
endinterface

### src/alr_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alr_ctrl
// Record/playback sequencer: positions, flags, phase counters and the
// configuration registers. Issues at most one store access per accepted beat.
// ----------------------------------------------------------------------------
module alr_ctrl #(
    parameter int STORE_DEPTH     = 131072,
    parameter int STORE_ADDR_BITS = 17
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                accept,
    input  logic [alr_pkg::OP_W-1:0]            op,
    input  logic signed [alr_pkg::SAMPLE_W-1:0] in_sample,
    input  logic                                cfg_wr_en,
    input  logic [alr_pkg::CFG_IDX_W-1:0]       cfg_addr,
    input  logic [alr_pkg::CFG_DATA_W-1:0]      cfg_wdata,
    output alr_pkg::mem_ctl_t                   mem_ctl,
    output logic [STORE_ADDR_BITS-1:0]          mem_addr,
    output logic [alr_pkg::BYTE_W-1:0]          mem_wdata,
    output alr_pkg::beat_info_t                 info
);

    localparam int LIM_W = (STORE_ADDR_BITS + 1 > alr_pkg::CAP_W) ?
                           STORE_ADDR_BITS + 1 : alr_pkg::CAP_W;

    logic [STORE_ADDR_BITS-1:0]  write_pos_reg, write_pos_next;
    logic [STORE_ADDR_BITS-1:0]  read_pos_reg, read_pos_next;
    logic [STORE_ADDR_BITS-1:0]  loop_len_reg, loop_len_next;
    logic                        recording_reg, recording_next;
    logic                        playing_reg, playing_next;
    logic                        phase_reg, phase_next;
    logic [1:0]                  quarter_reg, quarter_next;
    logic                        full_reg, full_next;
    logic [alr_pkg::OCT_W-1:0]   octave_reg, octave_next;
    logic [alr_pkg::CAP_W-1:0]   capacity_reg, capacity_next;

    logic [LIM_W-1:0]            cap_ext;
    logic [LIM_W-1:0]            cap_clip;
    logic [LIM_W-1:0]            limit_ext;
    logic [STORE_ADDR_BITS-1:0]  limit;
    logic [STORE_ADDR_BITS-1:0]  write_inc;
    logic [STORE_ADDR_BITS-1:0]  read_inc;
    logic                        rec_tick;
    logic                        play_tick;
    logic                        do_write;
    logic                        do_read;
    logic                        advance;
    alr_pkg::op_t                op_code;

    // Write limit: capacity clipped to the store depth, less one.
    always_comb
    begin
        cap_ext   = LIM_W'(capacity_reg);
        cap_clip  = (cap_ext > LIM_W'(STORE_DEPTH)) ? LIM_W'(STORE_DEPTH) : cap_ext;
        limit_ext = (cap_clip == '0) ? '0 : cap_clip - LIM_W'(1);
        limit     = limit_ext[STORE_ADDR_BITS-1:0];
    end

    // Decode of the accepted beat.
    always_comb
    begin
        op_code   = alr_pkg::op_t'(op);
        rec_tick  = accept && (op_code == alr_pkg::OP_TICK) && recording_reg;
        play_tick = accept && (op_code == alr_pkg::OP_TICK) && !recording_reg
                    && playing_reg;
        do_write  = rec_tick && phase_reg && (write_pos_reg < limit);
        do_read   = play_tick && (loop_len_reg != '0);
        write_inc = write_pos_reg + STORE_ADDR_BITS'(1);
        read_inc  = read_pos_reg + STORE_ADDR_BITS'(1);
    end

    // Read position moves on at a rate set by the octave register.
    always_comb
    begin
        unique case (octave_reg)
            alr_pkg::OCT_HALF:   advance = (quarter_reg == 2'd0);
            alr_pkg::OCT_NORMAL: advance = phase_reg;
            alr_pkg::OCT_DOUBLE: advance = 1'b1;
            default:             advance = 1'b0;
        endcase
    end

    // Next state of the sequencer and the configuration registers.
    always_comb
    begin
        write_pos_next = write_pos_reg;
        read_pos_next  = read_pos_reg;
        loop_len_next  = loop_len_reg;
        recording_next = recording_reg;
        playing_next   = playing_reg;
        phase_next     = phase_reg;
        quarter_next   = quarter_reg;
        full_next      = full_reg;
        octave_next    = octave_reg;
        capacity_next  = capacity_reg;

        if (accept)
        begin
            unique case (op_code)
                alr_pkg::OP_RECORD:
                begin
                    recording_next = 1'b1;
                    playing_next   = 1'b0;
                    write_pos_next = '0;
                end
                alr_pkg::OP_PLAY:
                begin
                    loop_len_next  = write_pos_reg;
                    playing_next   = 1'b1;
                    recording_next = 1'b0;
                    read_pos_next  = '0;
                end
                alr_pkg::OP_STOP:
                begin
                    recording_next = 1'b0;
                    playing_next   = 1'b0;
                end
                alr_pkg::OP_TICK:
                begin
                    if (rec_tick)
                    begin
                        if (phase_reg)
                        begin
                            if (do_write)
                            begin
                                write_pos_next = write_inc;
                                full_next      = (write_inc >= limit);
                            end
                            else
                            begin
                                full_next = 1'b1;
                            end
                        end
                        phase_next = !phase_reg;
                    end
                    else if (play_tick)
                    begin
                        if (do_read && advance)
                        begin
                            read_pos_next = (read_inc >= loop_len_reg) ? '0 : read_inc;
                        end
                        phase_next   = !phase_reg;
                        quarter_next = quarter_reg + 2'd1;
                    end
                end
                default:
                begin
                end
            endcase
        end

        // The user must write configuration only while the block is idle; the block itself does not enforce it.
        if (cfg_wr_en)
        begin
            unique case (cfg_addr)
                alr_pkg::CFG_OCTAVE:
                begin
                    octave_next = cfg_wdata[alr_pkg::OCT_W-1:0];
                    phase_next  = 1'b1;
                end
                alr_pkg::CFG_CAPACITY:
                begin
                    capacity_next = cfg_wdata[alr_pkg::CAP_W-1:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            write_pos_reg <= '0;
            read_pos_reg  <= '0;
            loop_len_reg  <= '0;
            recording_reg <= 1'b0;
            playing_reg   <= 1'b0;
            phase_reg     <= 1'b1;
            quarter_reg   <= 2'd0;
            full_reg      <= 1'b0;
            octave_reg    <= alr_pkg::OCT_RESET;
            capacity_reg  <= alr_pkg::CAP_RESET;
        end
        else
        begin
            write_pos_reg <= write_pos_next;
            read_pos_reg  <= read_pos_next;
            loop_len_reg  <= loop_len_next;
            recording_reg <= recording_next;
            playing_reg   <= playing_next;
            phase_reg     <= phase_next;
            quarter_reg   <= quarter_next;
            full_reg      <= full_next;
            octave_reg    <= octave_next;
            capacity_reg  <= capacity_next;
        end
    end

    // Store request: one port, write while recording, read while playing.
    always_comb
    begin
        mem_ctl.wr_en = do_write;
        mem_ctl.rd_en = do_read;
        mem_addr      = do_write ? write_pos_reg : read_pos_reg;
        mem_wdata     = in_sample[alr_pkg::SAMPLE_W-1 -: alr_pkg::BYTE_W]
                        ^ alr_pkg::BYTE_OFFSET;
        info.use_byte = do_read;
        info.play     = play_tick;
        info.full     = full_next;
    end

endmodule

### src/audio_loop_recorder_unit.sv
`timescale 1ns / 1ps
// A result beat is offered after the synchronous store read (first stage) and
// the output register; one command beat per cycle while results are taken.
// The single store port serves at most one access per beat, and the output
// register lets a new beat in while a result waits.
// Reset: positions, flags and the quarter counter clear, the phase bit is set,
// octave returns to normal speed and capacity to 131072; the store is not cleared.
// ----------------------------------------------------------------------------
// audio_loop_recorder_unit
// Lo-fi audio looper with varispeed playback over an 8-bit sample store.
// ----------------------------------------------------------------------------
module audio_loop_recorder_unit #(
    parameter int STORE_DEPTH     = 131072,
    parameter int STORE_ADDR_BITS = 17
) (
    input  logic                           clk,
    input  logic                           rst_n,
    alr_in_if.sink                         item,
    alr_out_if.source                      result,
    input  logic                           cfg_wr_en,
    input  logic [alr_pkg::CFG_IDX_W-1:0]  cfg_addr,
    input  logic [alr_pkg::CFG_DATA_W-1:0] cfg_wdata
);

    logic                              accept;
    alr_pkg::mem_ctl_t                 mem_ctl;
    logic [STORE_ADDR_BITS-1:0]        mem_addr;
    logic [alr_pkg::BYTE_W-1:0]        mem_wdata;
    alr_pkg::beat_info_t               info;

    logic [alr_pkg::BYTE_W-1:0]        store [STORE_DEPTH];
    logic [alr_pkg::BYTE_W-1:0]        rdata_reg;

    logic                              s1_valid_reg, s1_valid_next;
    alr_pkg::beat_info_t               s1_info_reg;
    logic                              s1_move;

    logic                              out_valid_reg, out_valid_next;
    logic signed [alr_pkg::SAMPLE_W-1:0] out_sample_reg;
    logic                              out_play_reg;
    logic                              out_full_reg;
    logic signed [alr_pkg::SAMPLE_W-1:0] s1_sample;

    // Handshake: a beat enters when the first stage is empty or moving on.
    assign s1_move    = s1_valid_reg && (!out_valid_reg || result.ready);
    assign item.ready = !s1_valid_reg || s1_move;
    assign accept     = item.valid && item.ready;

    alr_ctrl #(
        .STORE_DEPTH     (STORE_DEPTH),
        .STORE_ADDR_BITS (STORE_ADDR_BITS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .op        (item.op),
        .in_sample (item.in_sample),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .mem_ctl   (mem_ctl),
        .mem_addr  (mem_addr),
        .mem_wdata (mem_wdata),
        .info      (info)
    );

    // Sample store. Read data holds until the next read, which only comes
    // with a new beat, so a stalled first stage keeps its byte.
    always_ff @(posedge clk)
    begin
        if (mem_ctl.wr_en)
        begin
            store[mem_addr] <= mem_wdata;
        end
        if (mem_ctl.rd_en)
        begin
            rdata_reg <= store[mem_addr];
        end
    end

    // First stage: beat information while the store read completes.
    always_comb
    begin
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_move)
        begin
            s1_valid_next = 1'b0;
        end
        else
        begin
            s1_valid_next = s1_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_info_reg <= info;
        end
    end

    // Offset byte back to a signed sample in the upper half of the word.
    assign s1_sample = s1_info_reg.use_byte ?
                       {rdata_reg ^ alr_pkg::BYTE_OFFSET, (alr_pkg::BYTE_W)'(0)} : '0;

    // Output register.
    always_comb
    begin
        if (s1_move)
        begin
            out_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_move)
        begin
            out_sample_reg <= s1_sample;
            out_play_reg   <= s1_info_reg.play;
            out_full_reg   <= s1_info_reg.full;
        end
    end

    assign result.valid      = out_valid_reg;
    assign result.out_sample = out_sample_reg;
    assign result.out_valid  = out_play_reg;
    assign result.store_full = out_full_reg;

    // The single store port never sees a read and a write together.
    assert property (@(posedge clk) disable iff (!rst_n)
        !(mem_ctl.wr_en && mem_ctl.rd_en))
        else $error("store read and write requested in the same cycle");

    // A store access is only issued for a beat that is being taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        (mem_ctl.wr_en || mem_ctl.rd_en) |-> accept)
        else $error("store access without an accepted beat");

    // A full pipeline with a stalled output must hold off new beats.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && out_valid_reg && !result.ready) |-> !item.ready)
        else $error("beat accepted while both stages are stalled");

    // Results that are not playback carry silence.
    assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && !result.out_valid) |-> (result.out_sample == '0))
        else $error("nonzero sample outside playback");

endmodule
